FILE: src/isr_pkg.sv
// Shared types, widths and codes of the illumination source rasterizer.
package isr_pkg;

  // Field and register widths
  localparam int unsigned ModeW   = 3;
  localparam int unsigned GridW   = 11;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned FracW   = 17;
  localparam int unsigned PointW  = 18;
  localparam int unsigned CfgW    = 18;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned MaxGrid = 1 << CoordW;

  // Fixed-point fraction bits of all radii and offsets
  localparam int unsigned FracBits = 16;
  localparam int unsigned ShiftW   = 2 * FracBits;

  // Derived datapath widths
  localparam int unsigned CenterW = CoordW - 1;           // grid center
  localparam int unsigned DeltaW  = CoordW + 1;           // signed pixel offset from center
  localparam int unsigned LenW    = FracW + CenterW;      // length in 2^-16 pixel
  localparam int unsigned SqW     = 2 * LenW;             // squared length
  localparam int unsigned Dx2W    = 2 * CoordW - 1;       // squared pixel offset
  localparam int unsigned DsumW   = Dx2W + 1;             // sum of two squared offsets
  localparam int unsigned ProdW   = DeltaW + LenW + 1;    // signed offset times pole offset
  localparam int unsigned BaseW   = SqW + 1;              // squared distance plus offset square
  localparam int unsigned AccW    = BaseW + 4;            // signed pole distance accumulator
  localparam int unsigned MagW    = PointW;               // point offset magnitude
  localparam int unsigned PmW     = MagW + CenterW;       // point magnitude times center
  localparam int unsigned QW      = PmW - FracBits;       // truncated point shift
  localparam int unsigned PosW    = CoordW + 2;           // signed point position

  // Pipeline depth: five work stages and the output register
  localparam int unsigned NumStages = 6;

  // Register indexes of the configuration port
  typedef enum logic [IdxW-1:0] {
    RegMode        = 3'd0,
    RegGridSize    = 3'd1,
    RegInnerRadius = 3'd2,
    RegOuterRadius = 3'd3,
    RegPoleRadius  = 3'd4,
    RegPoleOffset  = 3'd5,
    RegPointX      = 3'd6,
    RegPointY      = 3'd7
  } reg_idx_e;

  // Shape codes of the mode register
  typedef enum logic [ModeW-1:0] {
    ModeAnnular = 3'd0,
    ModeDipoleX = 3'd1,
    ModeDipoleY = 3'd2,
    ModeQuad    = 3'd3,
    ModePoint   = 3'd4
  } mode_e;

  // Configuration register file
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [GridW-1:0]  grid_size;
    logic [FracW-1:0]  inner_radius;
    logic [FracW-1:0]  outer_radius;
    logic [FracW-1:0]  pole_radius;
    logic [FracW-1:0]  pole_offset;
    logic [PointW-1:0] point_x;
    logic [PointW-1:0] point_y;
  } cfg_t;

  // Per-stage load strobes from the pipeline control
  typedef struct packed {
    logic [NumStages-1:0] load;
  } stage_ctrl_t;

endpackage

FILE: src/isr_core.sv
// Arithmetic pipeline of the rasterizer: center, lengths, squares, sums, compares.
module isr_core import isr_pkg::*; (
  input  logic              clk_i,
  input  stage_ctrl_t       ctrl_i,
  input  cfg_t              cfg_i,
  input  logic [CoordW-1:0] col_i,
  input  logic [CoordW-1:0] row_i,
  output logic              lit_o
);

  localparam int unsigned PadC = PosW - CenterW;
  localparam int unsigned PadQ = PosW - QW;
  localparam int unsigned PadX = PosW - CoordW;

  // ---------------- stage 1: grid bounds and center ----------------
  logic [GridW-1:0]   gsat;
  logic [GridW-1:0]   gm1;
  logic               in1_d, in1_q;
  logic [CenterW-1:0] c1_d, c1_q;
  logic [CoordW-1:0]  x1_q, y1_q;

  always_comb begin
    gsat  = (cfg_i.grid_size > GridW'(MaxGrid)) ? GridW'(MaxGrid) : cfg_i.grid_size;
    gm1   = gsat - GridW'(1);
    c1_d  = gm1[CenterW:1];
    in1_d = (gsat != '0) && ({1'b0, col_i} < gsat) && ({1'b0, row_i} < gsat);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      in1_q <= in1_d;
      c1_q  <= c1_d;
      x1_q  <= col_i;
      y1_q  <= row_i;
    end
  end

  // ---------------- stage 2: offsets and scaled lengths ----------------
  logic                     in2_q;
  logic [CenterW-1:0]       c2_q;
  logic [CoordW-1:0]        x2_q, y2_q;
  logic signed [DeltaW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [LenW-1:0]          rin_q, rout_q, rp_q, off_q;
  logic [MagW-1:0]          magx, magy;
  logic [PmW-1:0]           pmx_q, pmy_q;

  always_comb begin
    dx_d = $signed({1'b0, x1_q}) - $signed({2'b00, c1_q});
    dy_d = $signed({1'b0, y1_q}) - $signed({2'b00, c1_q});
    magx = cfg_i.point_x[PointW-1] ? (~cfg_i.point_x + MagW'(1)) : cfg_i.point_x;
    magy = cfg_i.point_y[PointW-1] ? (~cfg_i.point_y + MagW'(1)) : cfg_i.point_y;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      in2_q  <= in1_q;
      c2_q   <= c1_q;
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      rin_q  <= LenW'(cfg_i.inner_radius) * LenW'(c1_q);
      rout_q <= LenW'(cfg_i.outer_radius) * LenW'(c1_q);
      rp_q   <= LenW'(cfg_i.pole_radius) * LenW'(c1_q);
      off_q  <= LenW'(cfg_i.pole_offset) * LenW'(c1_q);
      pmx_q  <= PmW'(magx) * PmW'(c1_q);
      pmy_q  <= PmW'(magy) * PmW'(c1_q);
    end
  end

  // ---------------- stage 3: squares, cross products, point hit ----------------
  logic                    in3_q;
  logic signed [2*DeltaW-1:0] dxsq, dysq;
  logic [Dx2W-1:0]         dxs_q, dys_q;
  logic signed [ProdW-1:0] dxo_d, dyo_d, dxo_q, dyo_q;
  logic [SqW-1:0]          off2_q, rin2_q, rout2_q, rad2_q;
  logic [QW-1:0]           qx, qy;
  logic signed [PosW-1:0]  cpos, px, py;
  logic                    pt_d, pt3_q;

  always_comb begin
    dxsq  = $signed({{DeltaW{dx_q[DeltaW-1]}}, dx_q}) * $signed({{DeltaW{dx_q[DeltaW-1]}}, dx_q});
    dysq  = $signed({{DeltaW{dy_q[DeltaW-1]}}, dy_q}) * $signed({{DeltaW{dy_q[DeltaW-1]}}, dy_q});
    dxo_d = $signed({{(ProdW-DeltaW){dx_q[DeltaW-1]}}, dx_q})
          * $signed({{(ProdW-LenW){1'b0}}, off_q});
    dyo_d = $signed({{(ProdW-DeltaW){dy_q[DeltaW-1]}}, dy_q})
          * $signed({{(ProdW-LenW){1'b0}}, off_q});
    // truncate point shift toward zero, then place it around the center
    qx    = pmx_q[PmW-1:FracBits];
    qy    = pmy_q[PmW-1:FracBits];
    cpos  = $signed({{PadC{1'b0}}, c2_q});
    px    = cfg_i.point_x[PointW-1] ? cpos - $signed({{PadQ{1'b0}}, qx})
                                     : cpos + $signed({{PadQ{1'b0}}, qx});
    py    = cfg_i.point_y[PointW-1] ? cpos - $signed({{PadQ{1'b0}}, qy})
                                     : cpos + $signed({{PadQ{1'b0}}, qy});
    pt_d  = (px == $signed({{PadX{1'b0}}, x2_q})) && (py == $signed({{PadX{1'b0}}, y2_q}));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      in3_q   <= in2_q;
      dxs_q   <= dxsq[Dx2W-1:0];
      dys_q   <= dysq[Dx2W-1:0];
      dxo_q   <= dxo_d;
      dyo_q   <= dyo_d;
      off2_q  <= SqW'(off_q) * SqW'(off_q);
      rin2_q  <= SqW'(rin_q) * SqW'(rin_q);
      rout2_q <= SqW'(rout_q) * SqW'(rout_q);
      rad2_q  <= SqW'(rp_q) * SqW'(rp_q);
      pt3_q   <= pt_d;
    end
  end

  // ---------------- stage 4: squared distance and pole base ----------------
  logic                    in4_q, pt4_q;
  logic [DsumW-1:0]        dsum_d, dsum_q;
  logic [BaseW-1:0]        base_q;
  logic signed [ProdW-1:0] dxo4_q, dyo4_q;
  logic [SqW-1:0]          rin24_q, rout24_q, rad24_q;

  assign dsum_d = DsumW'(dxs_q) + DsumW'(dys_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[3]) begin
      in4_q    <= in3_q;
      pt4_q    <= pt3_q;
      dsum_q   <= dsum_d;
      base_q   <= BaseW'({dsum_d, {ShiftW{1'b0}}}) + BaseW'(off2_q);
      dxo4_q   <= dxo_q;
      dyo4_q   <= dyo_q;
      rin24_q  <= rin2_q;
      rout24_q <= rout2_q;
      rad24_q  <= rad2_q;
    end
  end

  // ---------------- stage 5: pole distances and annulus bounds ----------------
  logic                   in5_q, pt5_q, ann_lo_q, ann_hi_q;
  logic [SqW-1:0]         d2;
  logic signed [AccW-1:0] basew, xterm, yterm;
  logic signed [AccW-1:0] sxp_q, sxm_q, syp_q, sym_q;
  logic [SqW-1:0]         rad25_q;

  always_comb begin
    d2    = {dsum_q, {ShiftW{1'b0}}};
    basew = $signed({{(AccW-BaseW){1'b0}}, base_q});
    xterm = $signed({{(AccW-ProdW){dxo4_q[ProdW-1]}}, dxo4_q}) <<< (FracBits + 1);
    yterm = $signed({{(AccW-ProdW){dyo4_q[ProdW-1]}}, dyo4_q}) <<< (FracBits + 1);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[4]) begin
      in5_q    <= in4_q;
      pt5_q    <= pt4_q;
      ann_lo_q <= d2 >= rin24_q;
      ann_hi_q <= d2 <= rout24_q;
      sxp_q    <= basew - xterm;
      sxm_q    <= basew + xterm;
      syp_q    <= basew - yterm;
      sym_q    <= basew + yterm;
      rad25_q  <= rad24_q;
    end
  end

  // ---------------- stage 6: pole compares and shape select ----------------
  logic signed [AccW-1:0] radw;
  logic                   hxp, hxm, hyp, hym;
  logic                   lit_d, lit_q;

  always_comb begin
    radw = $signed({{(AccW-SqW){1'b0}}, rad25_q});
    hxp  = sxp_q <= radw;
    hxm  = sxm_q <= radw;
    hyp  = syp_q <= radw;
    hym  = sym_q <= radw;
    unique case (cfg_i.mode)
      ModeAnnular: lit_d = ann_lo_q && ann_hi_q;
      ModeDipoleX: lit_d = hxp || hxm;
      ModeDipoleY: lit_d = hyp || hym;
      ModeQuad:    lit_d = hxp || hxm || hyp || hym;
      ModePoint:   lit_d = pt5_q;
      default:     lit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[5]) begin
      lit_q <= in5_q && lit_d;
    end
  end

  assign lit_o = lit_q;

endmodule

FILE: src/illumination_source_rasterizer.sv
// Top level of the illumination source rasterizer: config registers and pipeline control.
//
// Usage:
//   Input channel: one request per pixel, col_i and row_i, handshake
//   in_valid_i / in_stall_o. Output channel: one request per pixel, lit_o,
//   handshake out_valid_o / out_stall_i. A request moves at a rising edge
//   where valid is high and stall is low.
//   Configuration: cfg_we_i writes cfg_data_i into the register cfg_idx_i
//   (mode, grid size, radii, pole offset, point offsets); write only while
//   no pixel is in flight.
//   Pipeline: an accepted pixel passes the six register stages (center,
//   scaled lengths, squares, sums, compares, output) before out_valid_o
//   rises for it; a stalled output can hold it on the way.
//   Throughput: one pixel per cycle while out_stall_i is low.
//   Reset: rst_ni low clears all stage valid bits and loads the register
//   defaults (annulus mode, 1024 grid, outer radius one, the rest zero).
//   Stall: a stalled output holds its result; bubbles in the pipeline still
//   close up, and in_stall_o rises only when every stage holds a pixel.
module illumination_source_rasterizer import isr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CoordW-1:0] col_i,
  input  logic [CoordW-1:0] row_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              lit_o
);

  cfg_t                 cfg_q;
  logic [NumStages-1:0] valid_q;
  stage_ctrl_t          ctrl;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= ModeAnnular;
      cfg_q.grid_size    <= GridW'(MaxGrid);
      cfg_q.inner_radius <= '0;
      cfg_q.outer_radius <= FracW'(1 << FracBits);
      cfg_q.pole_radius  <= '0;
      cfg_q.pole_offset  <= '0;
      cfg_q.point_x      <= '0;
      cfg_q.point_y      <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegMode:        cfg_q.mode         <= cfg_data_i[ModeW-1:0];
        RegGridSize:    cfg_q.grid_size    <= cfg_data_i[GridW-1:0];
        RegInnerRadius: cfg_q.inner_radius <= cfg_data_i[FracW-1:0];
        RegOuterRadius: cfg_q.outer_radius <= cfg_data_i[FracW-1:0];
        RegPoleRadius:  cfg_q.pole_radius  <= cfg_data_i[FracW-1:0];
        RegPoleOffset:  cfg_q.pole_offset  <= cfg_data_i[FracW-1:0];
        RegPointX:      cfg_q.point_x      <= cfg_data_i[PointW-1:0];
        RegPointY:      cfg_q.point_y      <= cfg_data_i[PointW-1:0];
        default:        cfg_q.mode         <= cfg_q.mode;
      endcase
    end
  end

  // Load a stage when it is empty or its successor moves on
  always_comb begin
    ctrl.load[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ctrl.load[k] = !valid_q[k] || ctrl.load[k+1];
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ctrl.load[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (ctrl.load[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  isr_core u_core (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .cfg_i  (cfg_q),
    .col_i  (col_i),
    .row_i  (row_i),
    .lit_o  (lit_o)
  );

  assign in_stall_o  = !ctrl.load[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

FILE: src/isr_checker.sv
// Port-level checks of the rasterizer handshakes and in-flight count, bound to the top level.
module isr_checker import isr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic lit_o
);

  localparam int unsigned CntW = $clog2(NumStages + 1) + 1;

  logic            in_take, out_take;
  logic [CntW-1:0] inflight_q;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  // Track requests accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_take && !out_take) begin
      inflight_q <= inflight_q + CntW'(1);
    end else if (out_take && !in_take) begin
      inflight_q <= inflight_q - CntW'(1);
    end
  end

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped under stall");

  a_out_hold_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(lit_o))
    else $error("output payload changed under stall");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output is free");

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(NumStages))
    else $error("more requests in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0)
    else $error("output request without an accepted input");

endmodule

bind illumination_source_rasterizer isr_checker u_isr_checker (.*);
